@@ sv/gain_command_frame_parser_assert.svh @@
// Assertion helpers for the gain command frame parser.
`ifndef GAIN_COMMAND_FRAME_PARSER_ASSERT_SVH
`define GAIN_COMMAND_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define GCFP_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define GCFP_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gcfp_pkg.sv @@
package gcfp_pkg;

    // Bus widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 4;

    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  pos_t;
    typedef logic [1:0]  status_t;
    typedef logic [1:0]  gain_sel_t;
    typedef logic [31:0] word_t;

    // Frame bytes
    localparam byte_t HEADER_BYTE = 8'h24;   // '$'
    localparam byte_t CMD_P       = 8'h70;   // 'p'
    localparam byte_t CMD_I       = 8'h69;   // 'i'
    localparam byte_t CMD_D       = 8'h64;   // 'd'
    localparam byte_t MINUS_BYTE  = 8'h2D;   // '-'

    // Frame positions
    localparam pos_t POS_HEADER  = 3'd0;
    localparam pos_t POS_COMMAND = 3'd1;
    localparam pos_t POS_SIGN    = 3'd2;
    localparam pos_t POS_LAST    = 3'd7;

    // Float sign bit
    localparam word_t SIGN_MASK = 32'h8000_0000;

    // Result status codes
    localparam status_t ST_UPDATE   = 2'd0;
    localparam status_t ST_UNKNOWN  = 2'd1;
    localparam status_t ST_CHECKSUM = 2'd2;

    // Gain select codes
    localparam gain_sel_t SEL_P = 2'd0;
    localparam gain_sel_t SEL_I = 2'd1;
    localparam gain_sel_t SEL_D = 2'd2;

endpackage

@@ sv/gain_command_frame_parser.sv @@
// Gain command frame parser.
// Input stream s_axis carries one received serial byte per item. Bytes are
// dropped until a '$' header; the next seven bytes complete an 8-byte frame
// (command, sign, 4-byte little-endian float, checksum of bytes 0..6).
// Output stream m_axis carries one item per closed frame: tuser holds the
// status (gain update, unknown command, checksum error) and gain select,
// tdata holds the float bits with the sign applied (zero unless update).
// The checksum byte is accepted into the input register; once it fires, the
// result register loads and the frame's result appears on m_axis.
// Throughput: one byte per cycle while the result slot can take a new value;
// the input register and the result register form a two-stage pipe, so
// while a result waits one more byte is taken.
// Reset clears the frame position, the running sum and both valid flags;
// a partial frame is lost. When the receiver stalls with a result pending,
// the input register holds its byte and s_axis_tready drops once it is full;
// bytes that produce no result still only move when the result slot can
// take a new value.
module gain_command_frame_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    // input bytes
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gcfp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gcfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] gain_bits
    output logic [gcfp_pkg::OUT_TUSER_W-1:0] m_axis_tuser    // [1:0] status, [3:2] gain_select
);
    import gcfp_pkg::*;

    // Input register
    logic      in_valid_reg;
    byte_t     in_byte_reg;

    // Frame state
    pos_t      pos_reg;
    pos_t      pos_next;
    byte_t     sum_reg;
    byte_t     sum_next;
    byte_t     cmd_reg;
    logic      neg_reg;
    word_t     payload_reg;

    // Result register
    logic      out_valid_reg;
    status_t   out_status_reg;
    gain_sel_t out_sel_reg;
    word_t     out_bits_reg;

    logic      advance;
    logic      fire;
    logic      drop;
    logic      last;
    status_t   res_status;
    gain_sel_t res_sel;
    word_t     res_bits;
    logic [1:0] lane;

    // Handshake
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Frame decode
    assign drop = (pos_reg == POS_HEADER) && (in_byte_reg != HEADER_BYTE);
    assign last = (pos_reg == POS_LAST);
    assign lane = 2'(pos_reg - 3'd3);

    always_comb
    begin
        res_status = ST_UNKNOWN;
        res_sel    = SEL_P;
        res_bits   = '0;
        if (sum_reg != in_byte_reg)
        begin
            res_status = ST_CHECKSUM;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_P:
                begin
                    res_status = ST_UPDATE;
                    res_sel    = SEL_P;
                    res_bits   = payload_reg ^ (neg_reg ? SIGN_MASK : '0);
                end
                CMD_I:
                begin
                    res_status = ST_UPDATE;
                    res_sel    = SEL_I;
                    res_bits   = payload_reg ^ (neg_reg ? SIGN_MASK : '0);
                end
                CMD_D:
                begin
                    res_status = ST_UPDATE;
                    res_sel    = SEL_D;
                    res_bits   = payload_reg ^ (neg_reg ? SIGN_MASK : '0);
                end
                default:
                begin
                    res_status = ST_UNKNOWN;
                end
            endcase
        end
    end

    // Position and running sum
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (fire && !drop)
        begin
            if (last)
            begin
                pos_next = POS_HEADER;
                sum_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
                sum_next = sum_reg + in_byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HEADER;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Command, sign and payload capture
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (pos_reg == POS_COMMAND)
            begin
                cmd_reg <= in_byte_reg;
            end
            if (pos_reg == POS_SIGN)
            begin
                neg_reg <= (in_byte_reg == MINUS_BYTE);
            end
            if (pos_reg >= 3'd3 && !last)
            begin
                payload_reg[lane*8 +: 8] <= in_byte_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last)
        begin
            out_status_reg <= res_status;
            out_sel_reg    <= res_sel;
            out_bits_reg   <= res_bits;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_bits_reg;
    assign m_axis_tuser  = {out_sel_reg, out_status_reg};

    // Checks
    `include "gain_command_frame_parser_assert.svh"

    `GCFP_ASSERT_NEXT(a_last_emits, clk, rst_n, fire && last,
        out_valid_reg && pos_reg == POS_HEADER && sum_reg == '0,
        "checksum byte did not produce a result")
    `GCFP_ASSERT_NEXT(a_drop_holds, clk, rst_n, fire && drop,
        pos_reg == POS_HEADER && sum_reg == '0,
        "non-header byte moved the frame state")
    `GCFP_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid_reg && out_status_reg != ST_UPDATE,
        out_sel_reg == SEL_P && out_bits_reg == '0,
        "error result carries gain data")
    `GCFP_ASSERT_IMPL(a_full_stall, clk, rst_n, in_valid_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready,
        "input accepted while the pipe is full")
    `GCFP_ASSERT_NEXT(a_pos_step, clk, rst_n, fire && !drop && !last,
        pos_reg == $past(pos_reg) + 3'd1,
        "frame position skipped")

endmodule
